[hw/rtl/bppg_pkg.sv]
// Shared types and constants for the background pattern pixel generator.
// Depends on nothing; the divider pipeline and the top level import it.
package bppg_pkg;

	// Coordinate width default and the width that coordinates are widened to
	// for the constant divisions by ten and five.
	localparam int COORD_BITS_DEF = 12;
	localparam int COORD_EXT_W    = 16;

	// Color channels, eight bits each, blue in channel 0.
	localparam int NUM_CH = 3;
	localparam int CH_W   = 8;
	localparam int RGB_W  = NUM_CH * CH_W;

	// Gradient divisor is frame_width + frame_height.
	localparam int DIM_W  = 13;
	localparam int DEN_W  = DIM_W + 1;
	localparam int PROD_W = CH_W + DEN_W;
	localparam int QUOT_W = CH_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = RGB_W;

	// Reset values of the frame size registers.
	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1024);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(768);

	// Division by ten is a multiply by ceil(2^19/10) and a shift; the same
	// constant with a shift of 18 divides by five. Both are exact for any
	// 16-bit dividend.
	localparam int                MAGIC_W     = 17;
	localparam logic [MAGIC_W-1:0] DIV_MAGIC  = 17'd52429;
	localparam int                DIV10_SHIFT = 19;
	localparam int                DIV5_SHIFT  = 18;
	localparam int                Q10_W       = 13;

	typedef enum logic [1:0] {
		MODE_SOLID     = 2'd0,
		MODE_GRADIENT  = 2'd1,
		MODE_PATTERN   = 2'd2,
		MODE_SLIDESHOW = 2'd3
	} fill_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILL_MODE = 3'd0,
		REG_PRIMARY   = 3'd1,
		REG_SECONDARY = 3'd2,
		REG_WIDTH     = 3'd3,
		REG_HEIGHT    = 3'd4
	} cfg_reg_t;

	// Where the final color of a pixel comes from.
	typedef enum logic [1:0] {
		SRC_PRIMARY,
		SRC_SECONDARY,
		SRC_HALF,
		SRC_BLEND
	} src_t;

	typedef struct packed {
		logic valid;
		src_t src;
	} div_ctl_t;

	typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_vec_t;
	typedef logic [NUM_CH-1:0][QUOT_W-1:0] quot_vec_t;

endpackage

[hw/rtl/bppg_div_pipe.sv]
// Pipelined restoring divider for the three color channels, one quotient
// bit per stage. Depends on bppg_pkg.
module bppg_div_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bppg_pkg::div_ctl_t         ctl_in,
	input  logic [bppg_pkg::DEN_W-1:0] den,
	input  bppg_pkg::prod_vec_t        prod_in,
	output bppg_pkg::div_ctl_t         ctl_out,
	output bppg_pkg::quot_vec_t        quot_out
);
	import bppg_pkg::*;

	div_ctl_t  ctl_sd  [QUOT_W];
	quot_vec_t quot_sd [QUOT_W];
	prod_vec_t rem_sd  [QUOT_W-1];

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		localparam int BIT = QUOT_W - 1 - k;

		div_ctl_t          ctl_prev;
		prod_vec_t         rem_prev;
		quot_vec_t         quot_prev;
		quot_vec_t         quot_next;
		logic [NUM_CH-1:0] ge;
		logic [PROD_W-1:0] dsh;

		if (k == 0) begin : g_first
			assign ctl_prev  = ctl_in;
			assign rem_prev  = prod_in;
			assign quot_prev = '0;
		end else begin : g_next
			assign ctl_prev  = ctl_sd[k-1];
			assign rem_prev  = rem_sd[k-1];
			assign quot_prev = quot_sd[k-1];
		end

		assign dsh = PROD_W'(den) << BIT;

		always_comb begin
			quot_next = quot_prev;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				ge[ch] = (rem_prev[ch] >= dsh);
				quot_next[ch][BIT] = ge[ch];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sd[k] <= '0;
			end else begin
				ctl_sd[k] <= ctl_prev;
			end
		end

		always_ff @(posedge clk) begin
			quot_sd[k] <= quot_next;
		end

		// The last stage has no use for the remainder.
		if (k < QUOT_W - 1) begin : g_rem
			prod_vec_t rem_next;

			always_comb begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					rem_next[ch] = ge[ch] ? (rem_prev[ch] - dsh) : rem_prev[ch];
				end
			end

			always_ff @(posedge clk) begin
				rem_sd[k] <= rem_next;
			end
		end
	end

	assign ctl_out  = ctl_sd[QUOT_W-1];
	assign quot_out = quot_sd[QUOT_W-1];

endmodule

[hw/rtl/background_pattern_pixel_generator_unit.sv]
// Top level of the background pattern pixel generator: configuration
// registers, pattern decode, gradient scaling and the output register.
// Depends on bppg_pkg and bppg_div_pipe.

// The unit takes one pixel coordinate per clock on start and returns its
// 24-bit background color as a single-cycle beat on done with pixel_rgb;
// busy is never raised, so a coordinate may be offered in every cycle and
// results come back in the same order and at the same rate. Since the
// receiver cannot stall, it must take each beat in the cycle in which done
// is high. The latency is set by the gradient path: one stage clamps x+y
// and divides the coordinates by ten, one stage forms the channel
// differences times the clamped sum and finishes the checker decode, eight
// stages of a restoring divider produce one quotient bit each, and a last
// stage applies the quotient to the primary color and selects the result.
// Configuration writes through wr_en, wr_index and wr_data take effect at
// once and must only be made while no pixel is in flight, because the
// color and frame-size registers are read directly by several stages.
module background_pattern_pixel_generator_unit #(
	parameter int COORD_BITS = bppg_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [COORD_BITS-1:0]           pixel_x,
	input  logic [COORD_BITS-1:0]           pixel_y,
	output logic                            done,
	output logic [bppg_pkg::RGB_W-1:0]      pixel_rgb,
	input  logic                            wr_en,
	input  logic [bppg_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bppg_pkg::CFG_DATA_W-1:0] wr_data
);
	import bppg_pkg::*;

	localparam int SUM_W = ((COORD_BITS + 1) > DEN_W) ? (COORD_BITS + 1) : DEN_W;
	localparam int MUL10_W = COORD_EXT_W + MAGIC_W;
	localparam int MUL5_W  = Q10_W + MAGIC_W;

	// Magnitude of the difference between two channel values.
	function automatic logic [CH_W-1:0] chan_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
		return (b >= a) ? (b - a) : (a - b);
	endfunction

	// Move a toward b by mag; mag never exceeds the distance.
	function automatic logic [CH_W-1:0] chan_step(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
			logic [CH_W-1:0] mag);
		return (b >= a) ? (a + mag) : (a - mag);
	endfunction

	// Configuration registers.
	fill_mode_t       fill_mode_q;
	logic [RGB_W-1:0] primary_q;
	logic [RGB_W-1:0] secondary_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_mode_q <= MODE_GRADIENT;
			primary_q   <= '0;
			secondary_q <= '0;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FILL_MODE: fill_mode_q <= fill_mode_t'(wr_data[1:0]);
				REG_PRIMARY:   primary_q   <= wr_data[RGB_W-1:0];
				REG_SECONDARY: secondary_q <= wr_data[RGB_W-1:0];
				REG_WIDTH:     width_q     <= wr_data[DIM_W-1:0];
				REG_HEIGHT:    height_q    <= wr_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Gradient divisor; a zero sum of width and height is treated as a divisor of one.
	logic [DEN_W-1:0] den_raw;
	logic [DEN_W-1:0] den;

	assign den_raw = DEN_W'(width_q) + DEN_W'(height_q);
	assign den     = (den_raw == '0) ? DEN_W'(1) : den_raw;

	// The unit never refuses a coordinate.
	assign busy = 1'b0;

	// Stage 1: clamp x+y to the divisor and divide both coordinates by ten.
	logic                 accept;
	logic [SUM_W-1:0]     sum;
	logic [MUL10_W-1:0]   mul10_x;
	logic [MUL10_W-1:0]   mul10_y;
	logic                 valid_s1;
	logic [DEN_W-1:0]     num_s1;
	logic [Q10_W-1:0]     q10x_s1;
	logic [Q10_W-1:0]     q10y_s1;

	assign accept  = start && !busy;
	assign sum     = SUM_W'(pixel_x) + SUM_W'(pixel_y);
	assign mul10_x = MUL10_W'(COORD_EXT_W'(pixel_x)) * MUL10_W'(DIV_MAGIC);
	assign mul10_y = MUL10_W'(COORD_EXT_W'(pixel_y)) * MUL10_W'(DIV_MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		num_s1  <= (sum > SUM_W'(den)) ? den : DEN_W'(sum);
		q10x_s1 <= mul10_x[DIV10_SHIFT +: Q10_W];
		q10y_s1 <= mul10_y[DIV10_SHIFT +: Q10_W];
	end

	// Stage 2: channel products for the gradient, and the checker decode.
	// Dividing x/10 by five gives x/50; only the parities matter.
	logic [MUL5_W-1:0] mul5_x;
	logic [MUL5_W-1:0] mul5_y;
	logic              block_even;
	logic              cell_match;
	src_t              src_sel;
	div_ctl_t          ctl_s2;
	prod_vec_t         prod_s2;

	assign mul5_x     = MUL5_W'(q10x_s1) * MUL5_W'(DIV_MAGIC);
	assign mul5_y     = MUL5_W'(q10y_s1) * MUL5_W'(DIV_MAGIC);
	assign block_even = !(mul5_x[DIV5_SHIFT] ^ mul5_y[DIV5_SHIFT]);
	assign cell_match = (q10x_s1[0] == q10y_s1[0]);

	always_comb begin
		unique case (fill_mode_q) inside
			MODE_SOLID: begin
				src_sel = SRC_PRIMARY;
			end
			MODE_PATTERN: begin
				if (!block_even) begin
					src_sel = SRC_SECONDARY;
				end else if (cell_match) begin
					src_sel = SRC_PRIMARY;
				end else begin
					src_sel = SRC_HALF;
				end
			end
			MODE_GRADIENT, MODE_SLIDESHOW: begin
				src_sel = SRC_BLEND;
			end
			default: begin
				src_sel = SRC_BLEND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid <= valid_s1;
			ctl_s2.src   <= src_sel;
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod_s2[ch] <= PROD_W'(chan_diff(primary_q[ch*CH_W +: CH_W],
				secondary_q[ch*CH_W +: CH_W])) * PROD_W'(num_s1);
		end
	end

	// Stages 3 to 10: divide each product by the divisor.
	div_ctl_t  div_ctl;
	quot_vec_t div_quot;

	bppg_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_s2),
		.den      (den),
		.prod_in  (prod_s2),
		.ctl_out  (div_ctl),
		.quot_out (div_quot)
	);

	// Last stage: step from the primary color by the quotient, or pick one
	// of the fixed colors, and register the result beat.
	logic [RGB_W-1:0] color;
	logic             done_q;
	logic [RGB_W-1:0] pixel_rgb_q;

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			case (div_ctl.src)
				SRC_PRIMARY: begin
					color[ch*CH_W +: CH_W] = primary_q[ch*CH_W +: CH_W];
				end
				SRC_SECONDARY: begin
					color[ch*CH_W +: CH_W] = secondary_q[ch*CH_W +: CH_W];
				end
				SRC_HALF: begin
					color[ch*CH_W +: CH_W] = chan_step(primary_q[ch*CH_W +: CH_W],
						secondary_q[ch*CH_W +: CH_W],
						chan_diff(primary_q[ch*CH_W +: CH_W],
							secondary_q[ch*CH_W +: CH_W]) >> 1);
				end
				default: begin
					color[ch*CH_W +: CH_W] = chan_step(primary_q[ch*CH_W +: CH_W],
						secondary_q[ch*CH_W +: CH_W], div_quot[ch]);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		pixel_rgb_q <= color;
	end

	assign done      = done_q;
	assign pixel_rgb = pixel_rgb_q;

endmodule
